// ===== design/fsna_pkg.sv =====
// Shared types and constants for the font slot next-fit allocator.
package fsna_pkg;

	localparam int SLOT_COUNT  = 256;
	localparam int CHUNK_W     = (SLOT_COUNT >= 64) ? 32 : 2;
	localparam int CW_W        = $clog2(CHUNK_W);
	localparam int NCHUNK      = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
	localparam int CH_W        = $clog2(NCHUNK);
	localparam int SLOT_W      = CH_W + CW_W;
	localparam int PAD_COUNT   = NCHUNK * CHUNK_W;
	localparam int VC_W        = $clog2(NCHUNK + 1);

	localparam logic [SLOT_W:0]   SLOT_COUNT_X = (SLOT_W + 1)'(SLOT_COUNT);
	localparam logic [SLOT_W-1:0] FIRST_SLOT   = SLOT_W'(1);
	localparam logic [15:0]       AREA_LIMIT_RESET = 16'd2000;

	typedef enum logic [0:0] {
		CMD_ALLOCATE = 1'b0,
		CMD_RELEASE  = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED  = 3'd0,
		ST_INELIGIBLE = 3'd1,
		ST_FULL       = 3'd2,
		ST_RELEASED   = 3'd3,
		ST_IGNORED    = 3'd4
	} status_t;

	typedef struct packed {
		command_t    command;
		logic [7:0]  last_row;
		logic [15:0] last_column;
		logic [7:0]  glyph_row_bytes;
		logic [9:0]  glyph_height;
		logic [7:0]  release_slot;
	} item_t;

	typedef struct packed {
		logic [7:0] slot_number;
		status_t    status;
	} result_t;

endpackage

// ===== design/font_slot_next_fit_allocator.sv =====
// Next-fit font slot allocator: eligibility check and chunked free-slot scan.
//
//  channel  | signals                      | beat taken when
//  ---------+------------------------------+----------------------------
//  command  | start, busy, item            | start && !busy
//  result   | done, result                 | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// A command first passes the check step; release and ineligible
// requests finish there. An eligible allocate then scans the slot vector one
// CHUNK_W-bit chunk per cycle through one shared mask and priority encoder,
// from the pointer's chunk round the ring and back to it. done rises the
// cycle after the last step. Reset frees every slot at once and sets the
// pointer to slot 1. The result side cannot stall.
module font_slot_next_fit_allocator
	import fsna_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t                state_q;
	item_t                 item_q;
	logic [15:0]           limit_q;
	logic [PAD_COUNT-1:0]  slot_used_q;
	logic [SLOT_W-1:0]     ptr_q;
	logic [CH_W-1:0]       chunk_q;
	logic [VC_W-1:0]       vcnt_q;
	logic                  done_q;
	result_t               result_q;

	logic                  eligible;
	logic [17:0]           area;
	logic                  rel_ok;
	logic [SLOT_W-1:0]     rel_idx;
	logic [SLOT_W-1:0]     base;
	logic [CHUNK_W-1:0]    free_bits;
	logic                  hit;
	logic [CW_W-1:0]       hit_pos;
	logic [SLOT_W-1:0]     hit_idx;
	logic [SLOT_W:0]       next_ptr;
	logic                  first_visit;
	logic                  last_visit;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign area     = 18'(item_q.glyph_row_bytes) * 18'(item_q.glyph_height);
	assign eligible = (item_q.last_row == 8'd0) && (item_q.last_column[15:8] == 8'd0)
		&& (area < {2'b00, limit_q});
	assign rel_ok   = (item_q.release_slot != 8'd0)
		&& (32'(item_q.release_slot) < 32'(SLOT_COUNT));
	assign rel_idx  = SLOT_W'(item_q.release_slot);

	assign base        = {chunk_q, CW_W'(0)};
	assign first_visit = (vcnt_q == VC_W'(0));
	assign last_visit  = (vcnt_q == VC_W'(NCHUNK));

	// Mask out slot 0, padding, and the part of the ring outside this visit.
	always_comb begin
		logic [SLOT_W-1:0] g;
		logic              blocked;
		for (int j = 0; j < CHUNK_W; j++) begin
			g       = base | SLOT_W'(j);
			blocked = slot_used_q[base + SLOT_W'(j)]
				|| ({1'b0, g} >= SLOT_COUNT_X)
				|| (g == SLOT_W'(0))
				|| (first_visit && (g < ptr_q))
				|| (last_visit && (g >= ptr_q));
			free_bits[j] = !blocked;
		end
	end

	// Lowest free bit wins.
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int j = CHUNK_W - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				hit     = 1'b1;
				hit_pos = CW_W'(j);
			end
		end
	end

	assign hit_idx  = base | SLOT_W'(hit_pos);
	assign next_ptr = {1'b0, hit_idx} + (SLOT_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= AREA_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_used_q <= '0;
			ptr_q       <= FIRST_SLOT;
			chunk_q     <= '0;
			vcnt_q      <= '0;
			done_q      <= 1'b0;
			result_q    <= '{slot_number: 8'd0, status: ST_ALLOCATED};
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (item_q.command == CMD_RELEASE) begin
						if (rel_ok) begin
							slot_used_q[rel_idx] <= 1'b0;
							result_q <= '{slot_number: 8'd0, status: ST_RELEASED};
						end else begin
							result_q <= '{slot_number: 8'd0, status: ST_IGNORED};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!eligible) begin
						result_q <= '{slot_number: 8'd0, status: ST_INELIGIBLE};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						chunk_q <= ptr_q[SLOT_W-1:CW_W];
						vcnt_q  <= '0;
						done_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						slot_used_q[hit_idx] <= 1'b1;
						ptr_q    <= (next_ptr >= SLOT_COUNT_X) ? FIRST_SLOT
							: next_ptr[SLOT_W-1:0];
						result_q <= '{slot_number: 8'(hit_idx), status: ST_ALLOCATED};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (last_visit) begin
						ptr_q    <= FIRST_SLOT;
						result_q <= '{slot_number: 8'd0, status: ST_FULL};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						// advance to the next chunk, wrapping around the ring
						chunk_q <= (chunk_q == CH_W'(NCHUNK - 1)) ? CH_W'(0)
							: chunk_q + CH_W'(1);
						vcnt_q  <= vcnt_q + VC_W'(1);
						done_q  <= 1'b0;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != SLOT_W'(0)) && ({1'b0, ptr_q} < SLOT_COUNT_X))
		else $error("search pointer left the slot range");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CHECK || $past(state_q) == S_SCAN))
		else $error("result strobe without a finished command");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ALLOCATED) |-> (result.slot_number != 8'd0
			|| SLOT_COUNT > 256))
		else $error("slot 0 handed out");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (vcnt_q <= VC_W'(NCHUNK)))
		else $error("scan ran past its last chunk");

	a_start_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_CHECK))
		else $error("accepted command did not enter the check step");

endmodule

// ===== test/fsna_checker.sv =====
// Scoreboard for the font slot allocator: slot table predictor and result comparison.
`timescale 1ns / 1ps

module fsna_checker
	import fsna_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          outstanding
);

	localparam logic [7:0] TOP_SLOT = 8'(SLOT_COUNT - 1);

	logic [SLOT_COUNT-1:0] slot_used;
	logic [7:0]            scan_ptr;
	logic [15:0]           area_limit;
	result_t               slot_results_q[$];
	result_t               want;

	function automatic logic [7:0] next_slot(input logic [7:0] s);
		return (s == TOP_SLOT) ? FIRST_SLOT : s + 8'd1;
	endfunction

	// Apply one command beat to the slot table and return what the block must report.
	function automatic result_t grant_or_free(input item_t it);
		result_t     r;
		logic [17:0] area;
		logic [7:0]  slot;
		bit          found;
		r.slot_number = 8'd0;
		r.status      = ST_IGNORED;
		if (it.command == CMD_RELEASE) begin
			if (it.release_slot != 8'd0) begin
				slot_used[it.release_slot] = 1'b0;
				r.status = ST_RELEASED;
			end
		end else begin
			area = 18'(it.glyph_row_bytes) * 18'(it.glyph_height);
			if (it.last_row != 8'd0 || it.last_column >= 16'd256 ||
			    area >= {2'b00, area_limit}) begin
				r.status = ST_INELIGIBLE;
			end else begin
				found = 1'b0;
				slot  = scan_ptr;
				for (int n = 0; n < SLOT_COUNT - 1; n++) begin
					if (!found && !slot_used[slot]) begin
						found           = 1'b1;
						slot_used[slot] = 1'b1;
						r.slot_number   = slot;
						scan_ptr        = next_slot(slot);
					end
					if (!found)
						slot = next_slot(slot);
				end
				if (found) begin
					r.status = ST_ALLOCATED;
				end else begin
					scan_ptr = FIRST_SLOT;
					r.status = ST_FULL;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used      = '0;
			scan_ptr       = FIRST_SLOT;
			area_limit     = AREA_LIMIT_RESET;
			slot_results_q.delete();
			mismatch_count = 0;
			outstanding    = 0;
		end else begin
			// Retire the result before taking a new beat: both can land on one edge.
			if (done) begin
				if (slot_results_q.size() == 0) begin
					$error("result beat with nothing expected: slot_number %0d status %0d",
						result.slot_number, result.status);
					mismatch_count++;
				end else begin
					want = slot_results_q.pop_front();
					if (result.slot_number !== want.slot_number) begin
						$error("slot_number expected %0d actual %0d",
							want.slot_number, result.slot_number);
						mismatch_count++;
					end
					if (result.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				slot_results_q.push_back(grant_or_free(item));
			if (cfg_valid && cfg_ready)
				area_limit = cfg_data;
			outstanding = slot_results_q.size();
		end
	end

endmodule

// ===== test/tb_font_slot_next_fit_allocator.sv =====
// Top of the font slot allocator testbench: clock, reset, command and limit stimulus, verdict.
`timescale 1ns / 1ps

module tb_font_slot_next_fit_allocator
	import fsna_pkg::*;
();

	localparam int SETTLE_CYCLES = NCHUNK + 4;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	int          mismatch_count;
	int          outstanding;
	int          area_limit_now;

	font_slot_next_fit_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	fsna_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.done           (done),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic item_t make_item(input command_t c, input logic [7:0] row,
		input logic [15:0] col, input logic [7:0] rb, input logic [9:0] h,
		input logic [7:0] rel);
		item_t it;
		it.command         = c;
		it.last_row        = row;
		it.last_column     = col;
		it.glyph_row_bytes = rb;
		it.glyph_height    = h;
		it.release_slot    = rel;
		return it;
	endfunction

	// Eligible allocate: area kept under the current limit where the limit allows it.
	function automatic item_t fit_alloc();
		item_t it;
		int    rb;
		int    hmax;
		it = $bits(item_t)'({$urandom, $urandom});
		it.command     = CMD_ALLOCATE;
		it.last_row    = 8'd0;
		it.last_column = 16'($urandom_range(0, 255));
		if (area_limit_now <= 1) begin
			rb   = 0;
			hmax = 0;
		end else begin
			rb   = $urandom_range(0, 255);
			hmax = (rb == 0) ? 1023 : (area_limit_now - 1) / rb;
			if (hmax > 1023)
				hmax = 1023;
		end
		it.glyph_row_bytes = 8'(rb);
		it.glyph_height    = 10'($urandom_range(0, hmax));
		return it;
	endfunction

	function automatic item_t next_random(input bit filling);
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		it   = $bits(item_t)'({$urandom, $urandom});
		if (pick < (filling ? 80 : 40)) begin
			it = fit_alloc();
		end else if (pick < (filling ? 90 : 85)) begin
			it.command      = CMD_RELEASE;
			it.release_slot = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		end
		return it;
	endfunction

	// Hold the beat until the block takes it; start stays high for the caller to reuse.
	task automatic send_item(input item_t it);
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic sender_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= $bits(item_t)'({$urandom, $urandom});
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_area_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		area_limit_now = v;
	endtask

	// Alternate fill and churn stretches so the table both fills up and drains.
	task automatic run_random(input int count, input int idle_pct);
		int burst_left;
		bit filling;
		burst_left = 0;
		filling    = 1'b1;
		for (int k = 0; k < count; k++) begin
			if (k % 80 == 0)
				filling = (k == 0) || ($urandom_range(0, 2) != 0);
			if (idle_pct > 0) begin
				if (burst_left > 0)
					burst_left--;
				else if ($urandom_range(0, 99) < 3)
					burst_left = $urandom_range(10, 40);
				else if ($urandom_range(0, 99) < idle_pct)
					sender_gap($urandom_range(1, 4));
			end
			send_item(next_random(filling));
		end
	endtask

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		cfg_valid      = 1'b0;
		cfg_data       = 16'd0;
		area_limit_now = AREA_LIMIT_RESET;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_area_limit(AREA_LIMIT_RESET);
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd1, 16'd0, 8'd0, 10'd0, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd255, 16'd0, 8'd0, 10'd0, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd255, 8'd37, 10'd54, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd256, 8'd1, 10'd1, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'hFFFF, 8'd1, 10'd1, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd10, 8'd40, 10'd50, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd10, 8'hFF, 10'h3FF, 8'hFF));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd10, 8'd1, 10'h3FF, 8'd0));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd10, 8'hFF, 10'd7, 8'd0));
		send_item(make_item(CMD_RELEASE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd0));
		send_item(make_item(CMD_RELEASE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd255));
		send_item(make_item(CMD_RELEASE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd2));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd0));
		send_item(make_item(CMD_RELEASE, 8'hFF, 16'hFFFF, 8'hFF, 10'h3FF, 8'd255));
		send_item(make_item(CMD_RELEASE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd1));
		send_item(make_item(CMD_ALLOCATE, 8'd0, 16'd0, 8'd0, 10'd0, 8'd0));
		wait_drained();

		write_area_limit(16'hFFFF);
		run_random(500, 37);
		wait_drained();

		// Zero limit: every allocate must be refused.
		write_area_limit(16'd0);
		run_random(30, 0);
		wait_drained();

		write_area_limit(16'($urandom_range(1000, 40000)));
		run_random(500, 81);
		wait_drained();

		// Limit of one: only a zero area is eligible.
		write_area_limit(16'd1);
		run_random(30, 0);
		wait_drained();

		write_area_limit(16'($urandom_range(2000, 65535)));
		run_random(500, 0);
		wait_drained();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
